// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the spin update block.
// No dependencies; define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: hw/rtl/msu_pkg.sv
// Shared types and constants of the Metropolis spin update block.
// No dependencies; used by msu_cfg and metropolis_ising_spin_update.
package msu_pkg;

    // Acceptance thresholds: five registers, each two 17-bit thresholds.
    localparam int NUM_THR = 5;
    localparam int THR_W   = 17;
    localparam int REG_W   = 2 * THR_W;

    // Configuration port geometry: 64-bit data, registers at 8*i.
    localparam int CFG_DW  = 64;
    localparam int CFG_AW  = 6;
    localparam int IDX_LSB = 3;
    localparam int IDX_W   = 3;

    // Stream payloads.
    localparam int COORD_W = 8;
    localparam int RAND_W  = 16;
    localparam int IN_W    = 32;
    localparam int NSUM_W  = 4;
    localparam int MAG_W   = 18;
    localparam int OUT_W   = 24;

    typedef logic [NUM_THR-1:0][REG_W-1:0] thr_bank_t;

    // One APB request as seen by the register file.
    typedef struct packed {
        logic              psel;
        logic              penable;
        logic              pwrite;
        logic [CFG_AW-1:0] paddr;
        logic [CFG_DW-1:0] pwdata;
    } apb_req_t;

endpackage

// File: hw/rtl/msu_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies; holds the spin lattice.
module msu_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port; the data holds while re is low.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/msu_cfg.sv
// APB register file for the five acceptance threshold registers.
// Depends on msu_pkg for the request struct and the register geometry.
module msu_cfg
    import msu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  apb_req_t          req,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready,
    output thr_bank_t         thr_bank
);

    thr_bank_t        thr_bank_reg;
    thr_bank_t        thr_bank_next;
    logic             wr_en;
    logic [IDX_W-1:0] idx;

    assign pready = 1'b1;
    assign wr_en  = req.psel && req.penable && req.pwrite && pready;
    assign idx    = req.paddr[IDX_LSB +: IDX_W];

    // Register writes; an index beyond the list is ignored.
    always_comb
    begin
        thr_bank_next = thr_bank_reg;
        for (int i = 0; i < NUM_THR; i++)
        begin
            if (wr_en && idx == IDX_W'(i))
            begin
                thr_bank_next[i] = req.pwdata[REG_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_bank_reg <= '0;
        end
        else
        begin
            thr_bank_reg <= thr_bank_next;
        end
    end

    // Read back; unused addresses read as zero.
    always_comb
    begin
        prdata = '0;
        for (int i = 0; i < NUM_THR; i++)
        begin
            if (idx == IDX_W'(i))
            begin
                prdata = CFG_DW'(thr_bank_reg[i]);
            end
        end
    end

    assign thr_bank = thr_bank_reg;

endmodule

// File: hw/rtl/metropolis_ising_spin_update.sv
// Metropolis single-spin update on a SIDE x SIDE periodic Ising lattice.
// Depends on msu_pkg, msu_cfg, msu_ram and assert_macros.svh.
//
// One request names a site and brings a 16-bit random fraction; the block
// returns one result with the flip decision, the new spin, the neighbour
// sum taken before the update and the running magnetization. Items are
// handled one at a time: after acceptance the WRAP state reduces the
// coordinates modulo SIDE, the READ state issues five serial reads (site
// and four neighbours) to the single read port of the lattice memory,
// the ACC state collects the last read and the DECIDE state decides,
// writes back and loads the result into the output register. The next
// request is taken only back in idle, once the last one is through.
// A new request is taken while a finished result still waits on the
// master side; the decision stalls while that result is still waiting.
// After reset the lattice memory is cleared to all spins up, one site per
// cycle over all SIDE*SIDE sites (65536 at the default size); no request
// is accepted during that pass, while configuration writes are taken as
// usual. Row and column values of SIDE or more wrap modulo SIDE.
`include "assert_macros.svh"

module metropolis_ising_spin_update
    import msu_pkg::*;
#(
    parameter int SIDE = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    // APB configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready,
    // Slave side
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // tdata from bit 0: site_row[7:0], site_col[15:8], rand_fraction[31:16]
    input  logic [IN_W-1:0]   s_axis_tdata,
    // Master side
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // tdata from bit 0: flipped[0], new_spin[1], neighbor_sum[5:2],
    // magnetization[23:6]
    output logic [OUT_W-1:0]  m_axis_tdata
);

    localparam int CW    = $clog2(SIDE);
    localparam int DEPTH = SIDE * SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam int NCODE = 1 << COORD_W;

    localparam logic [AW-1:0]    SIDE_AW   = AW'(SIDE);
    localparam logic [AW-1:0]    LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [CW-1:0]    LAST_POS  = CW'(SIDE - 1);
    localparam logic [MAG_W-1:0] MAG_RESET = MAG_W'(DEPTH);
    localparam logic [MAG_W-1:0] MAG_STEP  = MAG_W'(2);

    // Read sequence codes.
    localparam logic [2:0] RD_CENTER = 3'd0;
    localparam logic [2:0] RD_UP     = 3'd1;
    localparam logic [2:0] RD_DN     = 3'd2;
    localparam logic [2:0] RD_RT     = 3'd3;
    localparam logic [2:0] RD_LF     = 3'd4;
    localparam logic [2:0] RD_LAST   = RD_LF;

    // Constant table: an 8-bit coordinate reduced modulo SIDE.
    function automatic logic [NCODE*CW-1:0] build_wrap();
        logic [NCODE*CW-1:0] tbl;
        tbl = '0;
        for (int i = 0; i < NCODE; i++)
        begin
            tbl[i*CW +: CW] = CW'(i % SIDE);
        end
        return tbl;
    endfunction

    localparam logic [NCODE*CW-1:0] WRAP_TBL = build_wrap();

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_WRAP   = 6'b000100,
        S_READ   = 6'b001000,
        S_ACC    = 6'b010000,
        S_DECIDE = 6'b100000
    } state_t;

    state_t             state_reg, state_next;
    logic [AW-1:0]      clr_addr_reg, clr_addr_next;
    logic [2:0]         rd_cnt_reg, rd_cnt_next;
    logic               rd_pend_reg, rd_pend_next;
    logic [2:0]         rd_kind_reg, rd_kind_next;
    logic [MAG_W-1:0]   mag_reg, mag_next;
    logic               out_valid_reg, out_valid_next;

    logic [COORD_W-1:0] row_raw_reg, row_raw_next;
    logic [COORD_W-1:0] col_raw_reg, col_raw_next;
    logic [RAND_W-1:0]  rnd_reg, rnd_next;
    logic [CW-1:0]      row_reg, row_next;
    logic [CW-1:0]      col_reg, col_next;
    logic [2:0]         downs_reg, downs_next;
    logic               cur_reg, cur_next;
    logic [AW-1:0]      ctr_addr_reg, ctr_addr_next;
    logic [OUT_W-1:0]   out_data_reg, out_data_next;

    apb_req_t           apb_req;
    thr_bank_t          thr_bank;

    logic [CW-1:0]      row_up, row_dn, col_rt, col_lf;
    logic [CW-1:0]      r_sel, c_sel;
    logic [AW-1:0]      rd_addr;
    logic               ram_we, ram_re;
    logic [AW-1:0]      ram_waddr;
    logic [0:0]         ram_wdata, ram_rdata;

    logic [IDX_W-1:0]   ridx;
    logic [THR_W-1:0]   thr_sel;
    logic               flip, nspin, dec_go;
    logic [NSUM_W-1:0]  nsum;
    logic [MAG_W-1:0]   mag_upd;

    // Configuration registers.
    assign apb_req = '{psel: psel, penable: penable, pwrite: pwrite,
                       paddr: paddr, pwdata: pwdata};

    msu_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (apb_req),
        .prdata   (prdata),
        .pready   (pready),
        .thr_bank (thr_bank)
    );

    // Neighbour coordinates with periodic wrap.
    assign row_up = (row_reg == LAST_POS) ? '0 : row_reg + CW'(1);
    assign row_dn = (row_reg == '0) ? LAST_POS : row_reg - CW'(1);
    assign col_rt = (col_reg == LAST_POS) ? '0 : col_reg + CW'(1);
    assign col_lf = (col_reg == '0) ? LAST_POS : col_reg - CW'(1);

    // Site chosen by the read sequence and its lattice address.
    always_comb
    begin
        case (rd_cnt_reg)
            RD_CENTER:
            begin
                r_sel = row_reg;
                c_sel = col_reg;
            end
            RD_UP:
            begin
                r_sel = row_up;
                c_sel = col_reg;
            end
            RD_DN:
            begin
                r_sel = row_dn;
                c_sel = col_reg;
            end
            RD_RT:
            begin
                r_sel = row_reg;
                c_sel = col_rt;
            end
            RD_LF:
            begin
                r_sel = row_reg;
                c_sel = col_lf;
            end
            default:
            begin
                r_sel = row_reg;
                c_sel = col_reg;
            end
        endcase
    end

    assign rd_addr = AW'(r_sel) * SIDE_AW + AW'(c_sel);

    // Decision: threshold by neighbour sum and current spin.
    assign ridx    = IDX_W'(NUM_THR - 1) - downs_reg;
    assign thr_sel = cur_reg ? thr_bank[ridx][REG_W-1:THR_W]
                             : thr_bank[ridx][THR_W-1:0];
    assign flip    = ({1'b0, rnd_reg} < thr_sel);
    assign nspin   = cur_reg ^ flip;
    assign nsum    = NSUM_W'(NUM_THR - 1) - {downs_reg, 1'b0};
    assign mag_upd = !flip ? mag_reg : (nspin ? mag_reg - MAG_STEP : mag_reg + MAG_STEP);
    assign dec_go  = (state_reg == S_DECIDE) && (!out_valid_reg || m_axis_tready);

    // Lattice memory: clearing pass or write-back of a flipped spin.
    assign ram_re    = (state_reg == S_READ);
    assign ram_we    = (state_reg == S_CLEAR) || (dec_go && flip);
    assign ram_waddr = (state_reg == S_CLEAR) ? clr_addr_reg : ctr_addr_reg;
    assign ram_wdata = (state_reg == S_CLEAR) ? 1'b0 : nspin;

    msu_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_lattice (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // Sequencer and next-state logic.
    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        rd_cnt_next    = rd_cnt_reg;
        rd_pend_next   = 1'b0;
        rd_kind_next   = rd_kind_reg;
        mag_next       = mag_reg;
        out_valid_next = out_valid_reg;
        row_raw_next   = row_raw_reg;
        col_raw_next   = col_raw_reg;
        rnd_next       = rnd_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        downs_next     = downs_reg;
        cur_next       = cur_reg;
        ctr_addr_next  = ctr_addr_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        // Collect the data of the read issued in the previous cycle.
        if (rd_pend_reg)
        begin
            if (rd_kind_reg == RD_CENTER)
            begin
                cur_next = ram_rdata[0];
            end
            else
            begin
                downs_next = downs_reg + 3'(ram_rdata[0]);
            end
        end

        case (state_reg)
            S_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    row_raw_next = s_axis_tdata[COORD_W-1:0];
                    col_raw_next = s_axis_tdata[2*COORD_W-1:COORD_W];
                    rnd_next     = s_axis_tdata[IN_W-1:2*COORD_W];
                    state_next   = S_WRAP;
                end
            end
            S_WRAP:
            begin
                row_next    = WRAP_TBL[row_raw_reg * CW +: CW];
                col_next    = WRAP_TBL[col_raw_reg * CW +: CW];
                downs_next  = '0;
                rd_cnt_next = RD_CENTER;
                state_next  = S_READ;
            end
            S_READ:
            begin
                rd_pend_next = 1'b1;
                rd_kind_next = rd_cnt_reg;
                if (rd_cnt_reg == RD_CENTER)
                begin
                    ctr_addr_next = rd_addr;
                end
                if (rd_cnt_reg == RD_LAST)
                begin
                    state_next = S_ACC;
                end
                else
                begin
                    rd_cnt_next = rd_cnt_reg + 3'd1;
                end
            end
            S_ACC:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (dec_go)
                begin
                    mag_next       = mag_upd;
                    out_valid_next = 1'b1;
                    out_data_next  = {mag_upd, nsum, nspin, flip};
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            rd_cnt_reg    <= RD_CENTER;
            rd_pend_reg   <= 1'b0;
            rd_kind_reg   <= RD_CENTER;
            mag_reg       <= MAG_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            rd_cnt_reg    <= rd_cnt_next;
            rd_pend_reg   <= rd_pend_next;
            rd_kind_reg   <= rd_kind_next;
            mag_reg       <= mag_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        row_raw_reg  <= row_raw_next;
        col_raw_reg  <= col_raw_next;
        rnd_reg      <= rnd_next;
        row_reg      <= row_next;
        col_reg      <= col_next;
        downs_reg    <= downs_next;
        cur_reg      <= cur_next;
        ctr_addr_reg <= ctr_addr_next;
        out_data_reg <= out_data_next;
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Checks on the sequencer.
    `ASSERT_IMPLIES(a_no_result_in_clear, clk, rst_n, state_reg == S_CLEAR, !out_valid_reg, "result shown during clearing pass")
    `ASSERT_IMPLIES(a_read_count_range, clk, rst_n, state_reg == S_READ, rd_cnt_reg <= RD_LAST, "read sequence overran")
    `ASSERT_NEXT(a_mag_hold_no_flip, clk, rst_n, dec_go && !flip, $stable(mag_reg), "magnetization moved without a flip")
    `ASSERT_NEXT(a_result_loaded, clk, rst_n, dec_go, out_valid_reg, "decided result not loaded")

endmodule

// File: test/metropolis_ising_spin_update_tb.sv
// Self-checking testbench for the Metropolis spin update block.
// Depends on msu_pkg and metropolis_ising_spin_update; needs no files or arguments.
// Tracks its own copy of the lattice and thresholds and checks every result.
`timescale 1ns / 1ps

module metropolis_ising_spin_update_tb;
    import msu_pkg::*;

    localparam int SIDE        = 256;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_WAIT  = 12;

    // Threshold register indexes, by neighbour sum.
    localparam int REG_SUM_MINUS4 = 0;
    localparam int REG_SUM_MINUS2 = 1;
    localparam int REG_SUM_ZERO   = 2;
    localparam int REG_SUM_PLUS2  = 3;
    localparam int REG_SUM_PLUS4  = 4;
    localparam int REG_UNUSED_LO  = NUM_THR;
    localparam int REG_UNUSED_HI  = 7;

    localparam logic [THR_W-1:0] THR_ALWAYS = 17'd65536;
    localparam logic [THR_W-1:0] THR_MAX    = 17'h1FFFF;

    typedef struct packed {
        logic                     flipped;
        logic                     new_spin;
        logic signed [NSUM_W-1:0] neighbor_sum;
        logic [MAG_W-1:0]         magnetization;
    } spin_result_t;

    logic              clk           = 1'b0;
    logic              rst_n         = 1'b0;
    logic              psel          = 1'b0;
    logic              penable       = 1'b0;
    logic              pwrite        = 1'b0;
    logic [CFG_AW-1:0] paddr         = '0;
    logic [CFG_DW-1:0] pwdata        = '0;
    logic [CFG_DW-1:0] prdata;
    logic              pready;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    // From bit 0: site_row[7:0], site_col[15:8], rand_fraction[31:16]
    logic [IN_W-1:0]   s_axis_tdata  = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    // From bit 0: flipped[0], new_spin[1], neighbor_sum[5:2], magnetization[23:6]
    logic [OUT_W-1:0]  m_axis_tdata;

    // Own copy of the lattice, the running spin sum and the threshold bank.
    bit           spin_grid [SIDE*SIDE];
    int           spin_total = SIDE * SIDE;
    thr_bank_t    thr_copy   = '0;
    spin_result_t expected_updates [$];

    int  mismatches  = 0;
    int  burst_left  = 0;
    bit  tx_steady   = 1'b0;
    logic rx_steady  = 1'b0;
    logic rx_hold    = 1'b0;
    bit  rx_open     = 1'b1;
    int  rx_run      = 0;
    event hold_go;

    metropolis_ising_spin_update #(
        .SIDE (SIDE)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 50 MHz clock.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Safety net against a hung handshake.
    initial
    begin
        #20_000_000;
        $display("FAIL metropolis_ising_spin_update");
        $finish;
    end

    // One Metropolis update on the local lattice copy; returns the result it should give.
    function automatic spin_result_t metropolis_step(input logic [COORD_W-1:0] row_in,
                                                     input logic [COORD_W-1:0] col_in,
                                                     input logic [RAND_W-1:0] frac);
        int               r;
        int               c;
        int               downs;
        logic             cur;
        logic             flip;
        logic [THR_W-1:0] limit;
        spin_result_t     res;
        r = int'(row_in) % SIDE;
        c = int'(col_in) % SIDE;
        downs = int'(spin_grid[((r + 1) % SIDE) * SIDE + c])
              + int'(spin_grid[((r + SIDE - 1) % SIDE) * SIDE + c])
              + int'(spin_grid[r * SIDE + (c + 1) % SIDE])
              + int'(spin_grid[r * SIDE + (c + SIDE - 1) % SIDE]);
        cur = spin_grid[r * SIDE + c];
        // The upper half of each register applies to a down spin.
        limit = cur ? thr_copy[REG_SUM_PLUS4 - downs][REG_W-1:THR_W]
                    : thr_copy[REG_SUM_PLUS4 - downs][THR_W-1:0];
        flip = ({1'b0, frac} < limit);
        if (flip)
        begin
            spin_grid[r * SIDE + c] = !cur;
            spin_total += cur ? 2 : -2;
        end
        res.flipped       = flip;
        res.new_spin      = cur ^ flip;
        res.neighbor_sum  = NSUM_W'(4 - 2 * downs);
        res.magnetization = MAG_W'(spin_total);
        return res;
    endfunction

    // Writes one threshold register over the configuration port.
    task automatic write_thresholds(input int idx, input logic [CFG_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_AW'(idx << IDX_LSB);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx < NUM_THR)
        begin
            thr_copy[idx] = value[REG_W-1:0];
        end
        @(posedge clk);
    endtask

    // Offers one request, records its expected result and then maybe pauses.
    task automatic send_site(input logic [COORD_W-1:0] row_in,
                             input logic [COORD_W-1:0] col_in,
                             input logic [RAND_W-1:0] frac);
        int gap;
        s_axis_tdata  <= {frac, col_in, row_in};
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        expected_updates.push_back(metropolis_step(row_in, col_in, frac));
        // Bursts of back-to-back requests separated by random gaps, unless tx_steady is set.
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            if (!tx_steady)
            begin
                gap = $urandom_range(1, 12);
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        else
        begin
            burst_left--;
        end
    endtask

    // Lets every outstanding result arrive and the block settle.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_updates.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    function automatic logic [THR_W-1:0] random_threshold();
        case ($urandom_range(0, 4))
            0:       return THR_ALWAYS;
            1:       return THR_MAX;
            2:       return '0;
            default: return THR_W'($urandom_range(0, 65536));
        endcase
    endfunction

    // Random thresholds in every register, with random junk above bit 33.
    task automatic load_random_thresholds();
        logic [CFG_DW-1:0] value;
        for (int i = REG_SUM_MINUS4; i <= REG_SUM_PLUS4; i++)
        begin
            value = {$urandom, $urandom};
            value[REG_W-1:0] = {random_threshold(), random_threshold()};
            write_thresholds(i, value);
        end
    endtask

    // Thresholds at reset are zero, so nothing may flip.
    task automatic test_reset_thresholds();
        send_site(8'd0, 8'd0, 16'd0);
        send_site(8'd255, 8'd255, 16'd0);
        send_site(8'd0, 8'd255, 16'h8000);
        send_site(8'd255, 8'd0, 16'hFFFF);
    endtask

    // Always-flip thresholds; surround the corner site one neighbour at a time.
    task automatic test_always_flip();
        logic [COORD_W-1:0] nb_row [4] = '{8'd1, 8'd255, 8'd0, 8'd0};
        logic [COORD_W-1:0] nb_col [4] = '{8'd0, 8'd0, 8'd1, 8'd255};
        wait_idle();
        for (int i = REG_SUM_MINUS4; i <= REG_SUM_PLUS4; i++)
        begin
            write_thresholds(i, '1);
        end
        for (int k = 0; k < 4; k++)
        begin
            send_site(nb_row[k], nb_col[k], 16'hFFFF);
            send_site(8'd0, 8'd0, 16'd0);
            send_site(8'd0, 8'd0, 16'hFFFF);
        end
    endtask

    // Compare boundaries of the threshold, writes to unused addresses and a zero threshold.
    task automatic test_threshold_edges();
        wait_idle();
        for (int i = REG_SUM_MINUS4; i <= REG_SUM_PLUS4; i++)
        begin
            write_thresholds(i, CFG_DW'({THR_ALWAYS, 17'd1}));
        end
        // These addresses hold no register, so the bank must stay as it is.
        for (int i = REG_UNUSED_LO; i <= REG_UNUSED_HI; i++)
        begin
            write_thresholds(i, '1);
        end
        send_site(8'd128, 8'd128, 16'd1);
        send_site(8'd128, 8'd128, 16'd0);
        send_site(8'd128, 8'd128, 16'hFFFF);
        wait_idle();
        write_thresholds(REG_SUM_PLUS4, '0);
        send_site(8'd128, 8'd128, 16'd0);
    endtask

    // Random requests, mostly crowded into a small patch so that neighbours interact.
    task automatic send_random_sites(input int count, input logic [COORD_W-1:0] base_row,
                                     input logic [COORD_W-1:0] base_col, input int span);
        logic [COORD_W-1:0] r;
        logic [COORD_W-1:0] c;
        logic [RAND_W-1:0]  frac;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                r = base_row + COORD_W'($urandom_range(0, span - 1));
                c = base_col + COORD_W'($urandom_range(0, span - 1));
            end
            else
            begin
                r = COORD_W'($urandom);
                c = COORD_W'($urandom);
            end
            case ($urandom_range(0, 9))
                0:       frac = '0;
                1:       frac = '1;
                default: frac = RAND_W'($urandom);
            endcase
            send_site(r, c, frac);
        end
    endtask

    // Several random threshold settings, each with its own patch of the lattice.
    task automatic test_random_phases();
        logic [COORD_W-1:0] base_row;
        logic [COORD_W-1:0] base_col;
        for (int p = 0; p < 5; p++)
        begin
            wait_idle();
            load_random_thresholds();
            // Every other patch starts near the wrap-around corner.
            base_row = (p % 2 == 0) ? COORD_W'(252 + $urandom_range(0, 3)) : COORD_W'($urandom);
            base_col = (p % 2 == 0) ? COORD_W'(252 + $urandom_range(0, 3)) : COORD_W'($urandom);
            send_random_sites(160, base_row, base_col, $urandom_range(3, 8));
        end
    endtask

    // The receiver holds off for a long stretch while requests keep coming.
    task automatic test_backpressure();
        wait_idle();
        load_random_thresholds();
        tx_steady = 1'b1;
        -> hold_go;
        send_random_sites(40, 8'd100, 8'd100, 4);
        tx_steady = 1'b0;
    endtask

    // Neither side idles.
    task automatic test_steady_flow();
        wait_idle();
        load_random_thresholds();
        tx_steady = 1'b1;
        rx_steady <= 1'b1;
        send_random_sites(60, 8'd254, 8'd254, 5);
        tx_steady = 1'b0;
        rx_steady <= 1'b0;
    endtask

    // Long hold-off of the receiver, counted here.
    always
    begin
        @(hold_go);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    // Receiver ready: low during a hold-off, high in steady flow, else open and closed runs of random length.
    always @(posedge clk)
    begin
        if (rx_hold)
        begin
            m_axis_tready <= 1'b0;
        end
        else if (rx_steady)
        begin
            m_axis_tready <= 1'b1;
        end
        else
        begin
            if (rx_run == 0)
            begin
                rx_open = !rx_open;
                rx_run  = rx_open ? $urandom_range(1, 24) : $urandom_range(1, 6);
            end
            else
            begin
                rx_run--;
            end
            m_axis_tready <= rx_open;
        end
    end

    // Compares each result with the oldest expectation.
    always @(posedge clk)
    begin
        spin_result_t want;
        spin_result_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.flipped       = m_axis_tdata[0];
            got.new_spin      = m_axis_tdata[1];
            got.neighbor_sum  = m_axis_tdata[5:2];
            got.magnetization = m_axis_tdata[23:6];
            if (expected_updates.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("Unexpected result at %0t: tdata=%h", $realtime, m_axis_tdata);
                end
            end
            else
            begin
                want = expected_updates.pop_front();
                if (got.flipped !== want.flipped || got.new_spin !== want.new_spin
                    || got.neighbor_sum !== want.neighbor_sum
                    || got.magnetization !== want.magnetization)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("Mismatch at %0t: expected flipped=%0d new_spin=%0d sum=%0d mag=%0d",
                                 $realtime, want.flipped, want.new_spin,
                                 want.neighbor_sum, $signed(want.magnetization));
                        $display("    got flipped=%0d new_spin=%0d sum=%0d mag=%0d",
                                 got.flipped, got.new_spin, got.neighbor_sum,
                                 $signed(got.magnetization));
                    end
                end
            end
        end
    end

    // Test sequence.
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_thresholds();
        test_always_flip();
        test_threshold_edges();
        test_random_phases();
        test_backpressure();
        test_steady_flow();
        wait_idle();
        if (mismatches == 0)
        begin
            $display("PASS metropolis_ising_spin_update");
        end
        else
        begin
            $display("FAIL metropolis_ising_spin_update");
        end
        $finish;
    end

endmodule
